@@ src/mba_pkg.sv @@
// ----------------------------------------------------------------------------
// mba_pkg
// shared types, codes and default sizes for the mipmap box average block
// ----------------------------------------------------------------------------
package mba_pkg;

  localparam int unsigned MAX_TEXELS_DEF     = 4096;
  localparam int unsigned MAX_COMPONENTS_DEF = 4;
  localparam int unsigned VALUE_BITS_DEF     = 16;

  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned CX_W       = 12;
  localparam int unsigned CY_W       = 6;
  localparam int unsigned CZ_W       = 4;
  localparam int unsigned COMP_W     = 2;
  localparam int unsigned TVAL_W     = 16;
  localparam int unsigned RVAL_W     = 16;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned SIZE_W     = 4;
  localparam int unsigned NCOMP_W    = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LOG2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPONENTS = 2'd2;

  // dimension modes
  localparam logic [MODE_W-1:0] MODE_1D = 2'd0;
  localparam logic [MODE_W-1:0] MODE_2D = 2'd1;
  localparam logic [MODE_W-1:0] MODE_3D = 2'd2;

  // register reset values
  localparam logic [MODE_W-1:0]  DIM_MODE_RST   = MODE_2D;
  localparam logic [SIZE_W-1:0]  SIZE_LOG2_RST  = 4'd6;
  localparam logic [NCOMP_W-1:0] COMPONENTS_RST = 3'd4;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic              command;
    logic [LEVEL_W-1:0] level;
    logic [CX_W-1:0]   coord_x;
    logic [CY_W-1:0]   coord_y;
    logic [CZ_W-1:0]   coord_z;
    logic [COMP_W-1:0] component;
    logic [TVAL_W-1:0] texel_value;
  } mba_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic wr_en;
    logic issue;
    logic load_out;
  } mba_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic bad;
    logic is_read;
    logic walk_last;
    logic out_free;
  } mba_stat_t;

endpackage

@@ src/mba_if.sv @@
// ----------------------------------------------------------------------------
// mba channel interfaces
// request, response and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mba_req_if
  import mba_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [LEVEL_W-1:0] level;
  logic [CX_W-1:0]   coord_x;
  logic [CY_W-1:0]   coord_y;
  logic [CZ_W-1:0]   coord_z;
  logic [COMP_W-1:0] component;
  logic [TVAL_W-1:0] texel_value;

  modport source (
    output valid, command, level, coord_x, coord_y, coord_z, component, texel_value,
    input  ready
  );
  modport sink (
    input  valid, command, level, coord_x, coord_y, coord_z, component, texel_value,
    output ready
  );
endinterface

interface mba_rsp_if
  import mba_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [RVAL_W-1:0] result_value;
  logic              status;

  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

interface mba_cfg_if
  import mba_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

@@ src/mba_ram.sv @@
// ----------------------------------------------------------------------------
// mba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mba_ctrl.sv @@
// ----------------------------------------------------------------------------
// mba_ctrl
// sequencer: accept, check, write or walk the covered base texels, deliver result
// ----------------------------------------------------------------------------
module mba_ctrl
  import mba_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  input  mba_stat_t stat_i,
  output mba_ctrl_t ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    ctrl_o           = '0;
    req_ready_o      = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o    = 1'b1;
        ctrl_o.capture = req_valid_i;
        if (req_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.bad) begin
          state_d = S_FINISH;
        end else if (stat_i.is_read) begin
          state_d = S_WALK;
        end else begin
          ctrl_o.wr_en = 1'b1;
          state_d      = S_FINISH;
        end
      end
      S_WALK: begin
        ctrl_o.issue = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_write_only_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.wr_en |-> (!stat_i.bad && !stat_i.is_read))
    else $error("store written for a failed or read item");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && stat_i.walk_last) |=> (state_q == S_DRAIN))
    else $error("walk did not stop at the last texel");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load_out |-> stat_i.out_free)
    else $error("result loaded over a pending item");

  a_check_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |=> (state_q != S_CHECK && state_q != S_IDLE))
    else $error("check step repeated or skipped");

endmodule

@@ src/mba_dp.sv @@
// ----------------------------------------------------------------------------
// mba_dp
// datapath: registers, range checks, texel walk counters, base store,
// accumulator and result register
// ----------------------------------------------------------------------------
module mba_dp
  import mba_pkg::*;
#(
  parameter int unsigned MAX_TEXELS     = MAX_TEXELS_DEF,
  parameter int unsigned MAX_COMPONENTS = MAX_COMPONENTS_DEF,
  parameter int unsigned VALUE_BITS     = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  mba_item_t             item_i,
  input  mba_ctrl_t             ctrl_i,
  output mba_stat_t             stat_o,
  input  logic                  rsp_ready_i,
  output logic                  rsp_valid_o,
  output logic [RVAL_W-1:0]     result_value_o,
  output logic                  status_o
);

  localparam int unsigned DEPTH    = MAX_TEXELS * MAX_COMPONENTS;
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TXW      = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
  localparam int unsigned TEX_LOG2 = $clog2(MAX_TEXELS + 1) - 1;
  localparam int unsigned SUMW     = VALUE_BITS + TXW;

  // configuration registers
  logic [MODE_W-1:0]  mode_q;
  logic [SIZE_W-1:0]  size_q;
  logic [NCOMP_W-1:0] ncomp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= DIM_MODE_RST;
      size_q  <= SIZE_LOG2_RST;
      ncomp_q <= COMPONENTS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DIM_MODE:   mode_q  <= cfg_wdata_i[MODE_W-1:0];
        CFG_SIZE_LOG2:  size_q  <= cfg_wdata_i[SIZE_W-1:0];
        CFG_COMPONENTS: ncomp_q <= cfg_wdata_i[NCOMP_W-1:0];
        default: ;
      endcase
    end
  end

  // item registers
  mba_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      item_q <= item_i;
    end
  end

  // range checks
  logic               is_read;
  logic [LEVEL_W-1:0] eff_level;
  logic [2:0]         dims;
  logic [5:0]         tot_log2;
  logic [SIZE_W-1:0]  coord_sh;
  logic               use_y, use_z;
  logic               cfg_bad, size_bad, comp_bad, lvl_bad, coord_bad, bad;

  always_comb begin
    is_read   = (item_q.command == CMD_READ);
    eff_level = is_read ? item_q.level : '0;
    dims      = 3'({1'b0, mode_q}) + 3'd1;
    tot_log2  = 6'(size_q) * 6'(dims);
    use_y     = (mode_q != MODE_1D);
    use_z     = (mode_q == MODE_3D);
    cfg_bad   = (mode_q > MODE_3D) || (ncomp_q == '0) ||
                (ncomp_q > NCOMP_W'(MAX_COMPONENTS));
    size_bad  = (tot_log2 > 6'(TEX_LOG2));
    comp_bad  = (NCOMP_W'(item_q.component) >= ncomp_q);
    lvl_bad   = (eff_level > size_q);
    coord_sh  = size_q - eff_level;
    coord_bad = ((item_q.coord_x >> coord_sh) != '0) ||
                (use_y && ((item_q.coord_y >> coord_sh) != '0)) ||
                (use_z && ((item_q.coord_z >> coord_sh) != '0));
    bad       = cfg_bad || size_bad || comp_bad || lvl_bad || coord_bad;
  end

  // texel walk counters
  logic [TXW-1:0] i_q, j_q, k_q;
  logic [TXW-1:0] span_mask;
  logic           last_i, last_j, last_k, walk_last;

  always_comb begin
    span_mask = ~({TXW{1'b1}} << eff_level);
    last_i    = (i_q == span_mask);
    last_j    = !use_y || (j_q == span_mask);
    last_k    = !use_z || (k_q == span_mask);
    walk_last = last_i && last_j && last_k;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (ctrl_i.issue) begin
      if (!last_i) begin
        i_q <= i_q + TXW'(1);
      end else begin
        i_q <= '0;
        if (!last_j) begin
          j_q <= j_q + TXW'(1);
        end else begin
          j_q <= '0;
          k_q <= k_q + TXW'(1);
        end
      end
    end
  end

  // store address
  logic [TXW-1:0] tx, ty, tz, texel;
  logic [AW-1:0]  addr;

  always_comb begin
    tx    = (TXW'(item_q.coord_x) << eff_level) | i_q;
    ty    = use_y ? ((TXW'(item_q.coord_y) << eff_level) | j_q) : '0;
    tz    = use_z ? ((TXW'(item_q.coord_z) << eff_level) | k_q) : '0;
    texel = (tz << {size_q, 1'b0}) | (ty << size_q) | tx;
    addr  = AW'(texel) * AW'(ncomp_q) + AW'(item_q.component);
  end

  logic [VALUE_BITS-1:0] rdata;

  mba_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_en),
    .waddr_i (addr),
    .wdata_i (VALUE_BITS'(item_q.texel_value)),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  // accumulator
  logic            rd_pend_q;
  logic [SUMW-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= ctrl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      sum_q <= '0;
    end else if (rd_pend_q) begin
      sum_q <= sum_q + SUMW'(rdata);
    end
  end

  // result register
  logic [5:0]        avg_sh;
  logic [RVAL_W-1:0] avg;
  logic              out_valid_q;
  logic [RVAL_W-1:0] res_q;
  logic              stat_q;

  always_comb begin
    avg_sh = 6'(item_q.level) * 6'(dims);
    avg    = RVAL_W'(sum_q >> avg_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      res_q  <= (bad || !is_read) ? '0 : avg;
      stat_q <= bad ? STATUS_ERR : STATUS_OK;
    end
  end

  assign rsp_valid_o    = out_valid_q;
  assign result_value_o = res_q;
  assign status_o       = stat_q;

  assign stat_o.bad       = bad;
  assign stat_o.is_read   = is_read;
  assign stat_o.walk_last = walk_last;
  assign stat_o.out_free  = !out_valid_q || rsp_ready_i;

endmodule

@@ src/mipmap_box_average.sv @@
// ----------------------------------------------------------------------------
// mipmap_box_average
// a write or rejected item goes through check and finish to the result register
// a read issues 2^(level*dims) base store reads, one per covered texel
// one item is worked at a time; the next is accepted while a result waits
// reset sets config defaults and control; the base store holds no reset value
// ----------------------------------------------------------------------------
module mipmap_box_average
  import mba_pkg::*;
#(
  parameter int unsigned MAX_TEXELS     = MAX_TEXELS_DEF,
  parameter int unsigned MAX_COMPONENTS = MAX_COMPONENTS_DEF,
  parameter int unsigned VALUE_BITS     = VALUE_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mba_req_if.sink   req_i,
  mba_rsp_if.source rsp_o,
  mba_cfg_if.sink   cfg_i
);

  mba_item_t item;
  mba_ctrl_t ctrl;
  mba_stat_t stat;

  assign item.command     = req_i.command;
  assign item.level       = req_i.level;
  assign item.coord_x     = req_i.coord_x;
  assign item.coord_y     = req_i.coord_y;
  assign item.coord_z     = req_i.coord_z;
  assign item.component   = req_i.component;
  assign item.texel_value = req_i.texel_value;

  assign cfg_i.ready = 1'b1;

  mba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  mba_dp #(
    .MAX_TEXELS     (MAX_TEXELS),
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .VALUE_BITS     (VALUE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_wdata_i    (cfg_i.wdata),
    .item_i         (item),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .result_value_o (rsp_o.result_value),
    .status_o       (rsp_o.status)
  );

endmodule

@@ bench/tb_mipmap_box_average.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mipmap_box_average
// drives texel writes and mipmap reads through the request channel, rewrites
// the texture shape between phases and checks every response, in order,
// against a fixed value or a box filter kept in step with the writes.
// reads are only issued once every base entry they cover holds a written value
// ----------------------------------------------------------------------------
module tb_mipmap_box_average;
  import mba_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_TEXELS_DEF * MAX_COMPONENTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned DIR_ROWS    = 38;
  localparam int unsigned NUM_PHASES  = 12;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned DEAD_ITEMS  = 40;

  localparam logic [MODE_W-1:0] MODE_BAD = 2'd3;

  localparam bit CHK_FIXED = 1'b1;
  localparam bit CHK_PRED  = 1'b0;

  localparam logic [MODE_W-1:0]  PH_MODE  [NUM_PHASES] = '{
    MODE_2D, MODE_1D, MODE_3D, MODE_3D, MODE_BAD, MODE_2D,
    MODE_1D, MODE_3D, MODE_2D, MODE_2D, MODE_1D, MODE_2D
  };
  localparam logic [SIZE_W-1:0]  PH_SIZE  [NUM_PHASES] = '{
    4'd6, 4'd12, 4'd4, 4'd1, 4'd2, 4'd2, 4'd3, 4'd2, 4'd7, 4'd5, 4'd0, 4'd3
  };
  localparam logic [NCOMP_W-1:0] PH_NCOMP [NUM_PHASES] = '{
    3'd4, 3'd1, 3'd4, 3'd3, 3'd2, 3'd2, 3'd4, 3'd1, 3'd2, 3'd1, 3'd1, 3'd3
  };

  typedef struct packed {
    logic [RVAL_W-1:0] value;
    logic              status;
  } tex_result_t;

  typedef struct {
    bit                    is_reg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    mba_item_t             item;
    bit                    fixed;
    tex_result_t           expected;
  } dir_row_t;

  logic clk;
  logic rst_n;

  mba_req_if req ();
  mba_rsp_if rsp ();
  mba_cfg_if cfg ();

  mipmap_box_average uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  logic [MODE_W-1:0]  tex_mode;
  logic [SIZE_W-1:0]  tex_size;
  logic [NCOMP_W-1:0] tex_ncomp;
  logic [TVAL_W-1:0]  tex_store   [STORE_DEPTH];
  bit                 tex_written [STORE_DEPTH];

  tex_result_t pending_results[$];
  dir_row_t    dir_rows [DIR_ROWS];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches;
  int unsigned cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit cfg_ok();
    int unsigned dims;
    dims = int'(tex_mode) + 1;
    return tex_mode <= MODE_3D && tex_ncomp != 0 && tex_ncomp <= MAX_COMPONENTS_DEF &&
           int'(tex_size) * dims <= $clog2(MAX_TEXELS_DEF);
  endfunction

  function automatic bit req_rejected(mba_item_t it);
    int unsigned dims;
    int unsigned lvl;
    int unsigned lside;
    if (!cfg_ok()) return 1'b1;
    dims = int'(tex_mode) + 1;
    lvl = (it.command == CMD_WRITE) ? 0 : int'(it.level);
    if (it.component >= tex_ncomp) return 1'b1;
    if (lvl > tex_size) return 1'b1;
    lside = (1 << tex_size) >> lvl;
    if (it.coord_x >= lside) return 1'b1;
    if (dims >= 2 && it.coord_y >= lside) return 1'b1;
    if (dims >= 3 && it.coord_z >= lside) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int unsigned texel_addr(int unsigned x, int unsigned y, int unsigned z,
                                             int unsigned comp);
    int unsigned side;
    side = 1 << tex_size;
    return ((z * side + y) * side + x) * tex_ncomp + comp;
  endfunction

  // sums the covered base entries, reports the first one never written
  function automatic longint unsigned box_sum(mba_item_t it, output int missing);
    int unsigned dims, scale, sy, sz, tx, ty, tz, addr;
    longint unsigned acc;
    dims = int'(tex_mode) + 1;
    scale = 1 << it.level;
    sy = (dims >= 2) ? scale : 1;
    sz = (dims >= 3) ? scale : 1;
    acc = 0;
    missing = -1;
    for (int unsigned k = 0; k < sz; k++) begin
      for (int unsigned j = 0; j < sy; j++) begin
        for (int unsigned i = 0; i < scale; i++) begin
          tx = it.coord_x * scale + i;
          ty = (dims >= 2) ? it.coord_y * scale + j : 0;
          tz = (dims >= 3) ? it.coord_z * scale + k : 0;
          addr = texel_addr(tx, ty, tz, it.component);
          if (addr < STORE_DEPTH) begin
            if (!tex_written[addr]) begin
              if (missing < 0) missing = int'(addr);
            end else begin
              acc += tex_store[addr];
            end
          end
        end
      end
    end
    return acc;
  endfunction

  function automatic tex_result_t filter_texel(mba_item_t it);
    tex_result_t res;
    int unsigned dims, y, z, addr;
    longint unsigned acc;
    int missing;
    res.value = '0;
    res.status = STATUS_OK;
    if (req_rejected(it)) begin
      res.status = STATUS_ERR;
      return res;
    end
    dims = int'(tex_mode) + 1;
    if (it.command == CMD_WRITE) begin
      y = (dims >= 2) ? int'(it.coord_y) : 0;
      z = (dims >= 3) ? int'(it.coord_z) : 0;
      addr = texel_addr(it.coord_x, y, z, it.component);
      if (addr < STORE_DEPTH) begin
        tex_store[addr] = it.texel_value;
        tex_written[addr] = 1'b1;
      end
      return res;
    end
    acc = box_sum(it, missing);
    res.value = RVAL_W'(acc >> (int'(it.level) * dims));
    return res;
  endfunction

  function automatic mba_item_t random_request();
    mba_item_t it;
    int unsigned lvl, lside, hi, t, side;
    int missing;
    it.command     = ($urandom_range(99) < 55) ? CMD_READ : CMD_WRITE;
    it.level       = LEVEL_W'($urandom);
    it.coord_x     = CX_W'($urandom);
    it.coord_y     = CY_W'($urandom);
    it.coord_z     = CZ_W'($urandom);
    it.component   = COMP_W'($urandom);
    it.texel_value = TVAL_W'($urandom);
    if (cfg_ok() && $urandom_range(99) >= 10) begin
      if (it.command == CMD_READ && $urandom_range(99) < 90) begin
        it.level = LEVEL_W'($urandom_range(tex_size, 0));
      end
      if ($urandom_range(99) < 90) begin
        it.component = COMP_W'($urandom_range(tex_ncomp - 1, 0));
      end
      lvl = (it.command == CMD_WRITE) ? 0 : int'(it.level);
      if (lvl <= tex_size && $urandom_range(99) < 90) begin
        lside = (1 << tex_size) >> lvl;
        hi = lside - 1;
        // keep near the origin half the time so covered regions fill up
        if ($urandom_range(1) == 1 && hi > 1) hi = 1;
        it.coord_x = CX_W'($urandom_range(hi, 0));
        it.coord_y = CY_W'($urandom_range(hi, 0));
        it.coord_z = CZ_W'($urandom_range(hi, 0));
      end
    end
    // a read over entries not yet written turns into a write of the first one
    if (it.command == CMD_READ && !req_rejected(it)) begin
      void'(box_sum(it, missing));
      if (missing >= 0) begin
        side = 1 << tex_size;
        t = int'(missing) / tex_ncomp;
        it.command   = CMD_WRITE;
        it.component = COMP_W'(int'(missing) % tex_ncomp);
        it.coord_x   = CX_W'(t % side);
        it.coord_y   = CY_W'((t / side) % side);
        it.coord_z   = CZ_W'(t / (side * side));
      end
    end
    return it;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    dir_row_t r;
    r.is_reg   = 1'b1;
    r.reg_idx  = idx;
    r.reg_val  = CFG_DATA_W'(val);
    r.item     = '0;
    r.fixed    = 1'b0;
    r.expected = '0;
    return r;
  endfunction

  function automatic dir_row_t req_row(logic cmd, int unsigned lvl, int unsigned x,
                                       int unsigned y, int unsigned z, int unsigned comp,
                                       int unsigned tval, bit fixed, int unsigned ev,
                                       logic es);
    dir_row_t r;
    r.is_reg                = 1'b0;
    r.reg_idx               = '0;
    r.reg_val               = '0;
    r.item.command          = cmd;
    r.item.level            = LEVEL_W'(lvl);
    r.item.coord_x          = CX_W'(x);
    r.item.coord_y          = CY_W'(y);
    r.item.coord_z          = CZ_W'(z);
    r.item.component        = COMP_W'(comp);
    r.item.texel_value      = TVAL_W'(tval);
    r.fixed                 = fixed;
    r.expected.value        = RVAL_W'(ev);
    r.expected.status       = es;
    return r;
  endfunction

  task automatic send_request(input mba_item_t it, input bit fixed,
                              input tex_result_t fixed_res);
    tex_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.command     <= it.command;
    req.level       <= it.level;
    req.coord_x     <= it.coord_x;
    req.coord_y     <= it.coord_y;
    req.coord_z     <= it.coord_z;
    req.component   <= it.component;
    req.texel_value <= it.texel_value;
    do @(posedge clk); while (req.ready !== 1'b1);
    predicted = filter_texel(it);
    pending_results.push_back(fixed ? fixed_res : predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= val;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    case (idx)
      CFG_DIM_MODE:   tex_mode  = val[MODE_W-1:0];
      CFG_SIZE_LOG2:  tex_size  = val[SIZE_W-1:0];
      CFG_COMPONENTS: tex_ncomp = val[NCOMP_W-1:0];
      default: ;
    endcase
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_result(input logic [RVAL_W-1:0] value, input logic status);
    tex_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("response with no item pending: result_value %h status %0d", value, status);
      mismatches++;
    end else begin
      exp_res = pending_results.pop_front();
      if (value !== exp_res.value) begin
        $error("result_value mismatch: expected %h, actual %h", exp_res.value, value);
        mismatches++;
      end
      if (status !== exp_res.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_res.status, status);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        check_result(rsp.result_value, rsp.status);
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cycle_count     = 0;
    mismatches      = 0;
    send_idle_pct   = 15;
    recv_idle_pct   = 77;
    req.valid       = 1'b0;
    req.command     = CMD_WRITE;
    req.level       = '0;
    req.coord_x     = '0;
    req.coord_y     = '0;
    req.coord_z     = '0;
    req.component   = '0;
    req.texel_value = '0;
    rsp.ready       = 1'b0;
    cfg.valid       = 1'b0;
    cfg.index       = CFG_DIM_MODE;
    cfg.wdata       = '0;
    tex_mode        = DIM_MODE_RST;
    tex_size        = SIZE_LOG2_RST;
    tex_ncomp       = COMPONENTS_RST;

    dir_rows = '{
      // reset shape: 2d, 64 x 64, four components
      req_row(CMD_WRITE, 0, 63, 63, 15, 3, 'hFFFF, CHK_FIXED, 0, STATUS_OK),
      req_row(CMD_READ, 0, 63, 63, 0, 3, 0, CHK_FIXED, 'hFFFF, STATUS_OK),
      req_row(CMD_READ, 7, 0, 0, 0, 0, 0, CHK_FIXED, 0, STATUS_ERR),
      req_row(CMD_READ, 6, 1, 0, 0, 0, 0, CHK_FIXED, 0, STATUS_ERR),
      // level is ignored on writes
      req_row(CMD_WRITE, 15, 0, 0, 0, 0, 0, CHK_FIXED, 0, STATUS_OK),
      req_row(CMD_WRITE, 0, 64, 0, 0, 0, 'h1234, CHK_FIXED, 0, STATUS_ERR),
      req_row(CMD_READ, 15, 0, 0, 0, 0, 0, CHK_FIXED, 0, STATUS_ERR),
      reg_row(CFG_COMPONENTS, 3),
      req_row(CMD_WRITE, 0, 0, 0, 0, 3, 'h5555, CHK_FIXED, 0, STATUS_ERR),
      reg_row(CFG_DIM_MODE, MODE_BAD),
      req_row(CMD_READ, 0, 0, 0, 0, 0, 0, CHK_FIXED, 0, STATUS_ERR),
      req_row(CMD_WRITE, 0, 0, 0, 0, 0, 'hAAAA, CHK_FIXED, 0, STATUS_ERR),
      // widest line
      reg_row(CFG_DIM_MODE, MODE_1D),
      reg_row(CFG_SIZE_LOG2, 12),
      reg_row(CFG_COMPONENTS, 1),
      req_row(CMD_WRITE, 15, 4095, 63, 15, 0, 'h1234, CHK_FIXED, 0, STATUS_OK),
      req_row(CMD_READ, 0, 4095, 63, 15, 0, 0, CHK_FIXED, 'h1234, STATUS_OK),
      req_row(CMD_READ, 12, 1, 0, 0, 0, 0, CHK_FIXED, 0, STATUS_ERR),
      reg_row(CFG_SIZE_LOG2, 13),
      req_row(CMD_READ, 0, 0, 0, 0, 0, 0, CHK_FIXED, 0, STATUS_ERR),
      reg_row(CFG_SIZE_LOG2, 1),
      req_row(CMD_WRITE, 0, 0, 0, 0, 0, 'hFFFF, CHK_FIXED, 0, STATUS_OK),
      req_row(CMD_WRITE, 0, 1, 0, 0, 0, 'hFFFF, CHK_FIXED, 0, STATUS_OK),
      req_row(CMD_READ, 1, 0, 0, 0, 0, 0, CHK_FIXED, 'hFFFF, STATUS_OK),
      req_row(CMD_WRITE, 0, 1, 0, 0, 0, 'h0001, CHK_FIXED, 0, STATUS_OK),
      req_row(CMD_READ, 1, 0, 0, 0, 0, 0, CHK_PRED, 0, STATUS_OK),
      reg_row(CFG_COMPONENTS, 0),
      req_row(CMD_READ, 0, 0, 0, 0, 0, 0, CHK_FIXED, 0, STATUS_ERR),
      reg_row(CFG_COMPONENTS, 5),
      req_row(CMD_WRITE, 0, 0, 0, 0, 0, 'h0F0F, CHK_FIXED, 0, STATUS_ERR),
      reg_row(CFG_COMPONENTS, 1),
      reg_row(CFG_DIM_MODE, MODE_3D),
      reg_row(CFG_SIZE_LOG2, 5),
      req_row(CMD_READ, 0, 0, 0, 0, 0, 0, CHK_FIXED, 0, STATUS_ERR),
      // single texel volume
      reg_row(CFG_SIZE_LOG2, 0),
      req_row(CMD_WRITE, 0, 0, 0, 0, 0, 'hABCD, CHK_FIXED, 0, STATUS_OK),
      req_row(CMD_READ, 0, 0, 0, 0, 0, 0, CHK_FIXED, 'hABCD, STATUS_OK),
      req_row(CMD_WRITE, 0, 0, 1, 0, 0, 'h1111, CHK_FIXED, 0, STATUS_ERR)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_reg) begin
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        send_request(dir_rows[r].item, dir_rows[r].fixed, dir_rows[r].expected);
      end
    end

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p * 3 / NUM_PHASES)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(CFG_DIM_MODE, CFG_DATA_W'(PH_MODE[p]));
      write_reg(CFG_SIZE_LOG2, CFG_DATA_W'(PH_SIZE[p]));
      write_reg(CFG_COMPONENTS, CFG_DATA_W'(PH_NCOMP[p]));
      repeat (cfg_ok() ? PHASE_ITEMS : DEAD_ITEMS) begin
        send_request(random_request(), CHK_PRED, '0);
      end
    end

    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
